[sv/sorted_key_table_top_defines.svh]
// ----------------------------------------------------------------------------
// sorted_key_table_top_defines.svh
// assertion macros for the sorted key table
// ----------------------------------------------------------------------------
`ifndef SORTED_KEY_TABLE_TOP_DEFINES_SVH
`define SORTED_KEY_TABLE_TOP_DEFINES_SVH

`ifndef SYNTHESIS

// antecedent implies consequent in the same cycle
`define SKT_ASSERT_SAME(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sorted key table assertion failed");

// antecedent implies consequent in the next cycle
`define SKT_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sorted key table assertion failed");

`else

`define SKT_ASSERT_SAME(name, clk, rst_n, ante, cons)
`define SKT_ASSERT_NEXT(name, clk, rst_n, ante, cons)

`endif

`endif

[sv/skt_pkg.sv]
// ----------------------------------------------------------------------------
// skt_pkg
// shared types, codes and defaults of the sorted key table
// ----------------------------------------------------------------------------
package skt_pkg;

    localparam int DEF_CAPACITY = 64;
    localparam int DEF_KEY_BITS = 32;
    localparam int WORD_W       = 32;
    localparam int PAY_W        = 3 * WORD_W;

    localparam logic [1:0] CMD_INSERT = 2'd0;
    localparam logic [1:0] CMD_REMOVE = 2'd1;

    typedef enum logic [2:0] {
        STAT_INSERTED  = 3'd0,
        STAT_UPDATED   = 3'd1,
        STAT_REMOVED   = 3'd2,
        STAT_NOT_FOUND = 3'd3,
        STAT_FULL      = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_COMPARE,
        ST_DECIDE,
        ST_SHIFT,
        ST_WRITE
    } state_t;

    typedef struct packed {
        logic [WORD_W-1:0] data;
        logic [WORD_W-1:0] xfm;
        logic [WORD_W-1:0] scale;
    } payload_t;

endpackage

[sv/sorted_key_table_top.sv]
// ----------------------------------------------------------------------------
// sorted_key_table_top
// sorted key table with binary search, insert, remove and lookup on one memory
// ----------------------------------------------------------------------------
// each search probe is a memory read, then a compare; lookup and update finish once
//   the search ends, and done is raised in the same cycle that busy falls
// insert writes at once when appending, else first moves the later entries up one by
//   one; remove moves them down when it has any, through the single read and write port
// one item at a time: busy stays high from start until the done strobe; no result stall
// reset clears the entry count and the control state; memory contents need no clearing pass
`include "sorted_key_table_top_defines.svh"

module sorted_key_table_top #(
    parameter int CAPACITY = skt_pkg::DEF_CAPACITY,
    parameter int KEY_BITS = skt_pkg::DEF_KEY_BITS,
    localparam int IDX_W   = $clog2(CAPACITY),
    localparam int CNT_W   = $clog2(CAPACITY + 1)
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic [1:0]                cmd,
    input  logic [skt_pkg::WORD_W-1:0] key,
    input  logic [skt_pkg::WORD_W-1:0] data_ref,
    input  logic [skt_pkg::WORD_W-1:0] transform_ref,
    input  logic [skt_pkg::WORD_W-1:0] scale_bits,
    output logic                      done,
    output logic [2:0]                status,
    output logic                      found,
    output logic [CNT_W-1:0]          item_index,
    output logic [CNT_W-1:0]          entry_count,
    output logic [skt_pkg::WORD_W-1:0] data_out,
    output logic [skt_pkg::WORD_W-1:0] transform_out,
    output logic [skt_pkg::WORD_W-1:0] scale_out
);

    localparam int ENT_W = KEY_BITS + skt_pkg::PAY_W;
    localparam logic [CNT_W-1:0] CAP_C = CNT_W'(CAPACITY);

    // entry memory: key in the upper bits, payload below
    logic [ENT_W-1:0] mem [CAPACITY];
    logic [ENT_W-1:0] rd_data_reg;
    logic             mem_we;
    logic             mem_re;
    logic [IDX_W-1:0] mem_waddr;
    logic [IDX_W-1:0] mem_raddr;
    logic [ENT_W-1:0] mem_wdata;

    skt_pkg::state_t   state_reg, state_next;
    logic [1:0]        cmd_reg, cmd_next;
    logic [KEY_BITS-1:0] key_reg, key_next;
    skt_pkg::payload_t pay_reg, pay_next;
    skt_pkg::payload_t hit_pay_reg, hit_pay_next;
    logic [CNT_W-1:0]  lo_reg, lo_next;
    logic [CNT_W-1:0]  hi_reg, hi_next;
    logic [IDX_W-1:0]  mid_reg, mid_next;
    logic [CNT_W-1:0]  pos_reg, pos_next;
    logic              hit_reg, hit_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [IDX_W-1:0]  sh_idx_reg, sh_idx_next;
    logic [CNT_W-1:0]  sh_cnt_reg, sh_cnt_next;
    logic              sh_pend_reg, sh_pend_next;
    logic [IDX_W-1:0]  sh_src_reg, sh_src_next;
    logic              done_reg, done_next;
    skt_pkg::status_t  status_reg, status_next;
    logic              found_reg, found_next;
    logic [CNT_W-1:0]  index_reg, index_next;
    skt_pkg::payload_t out_pay_reg, out_pay_next;

    logic [KEY_BITS-1:0] key_in;
    logic [CNT_W:0]      lohi_sum;
    logic [IDX_W-1:0]    mid_c;
    logic                probe_left;
    logic [KEY_BITS-1:0] rd_key;
    logic                key_eq;
    logic                key_lt;
    logic                is_insert;
    logic                is_remove;
    logic                is_full;
    logic                shift_done;

    generate
        if (KEY_BITS <= skt_pkg::WORD_W) begin : g_key_narrow
            assign key_in = key[KEY_BITS-1:0];
        end else begin : g_key_wide
            assign key_in = {{(KEY_BITS - skt_pkg::WORD_W){1'b0}}, key};
        end
    endgenerate

    assign lohi_sum   = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign mid_c      = lohi_sum[IDX_W:1];
    assign probe_left = lo_reg < hi_reg;
    assign rd_key     = rd_data_reg[ENT_W-1 -: KEY_BITS];
    assign key_eq     = key_reg == rd_key;
    assign key_lt     = key_reg < rd_key;
    assign is_insert  = cmd_reg == skt_pkg::CMD_INSERT;
    assign is_remove  = cmd_reg == skt_pkg::CMD_REMOVE;
    assign is_full    = count_reg == CAP_C;
    assign shift_done = (sh_cnt_reg == '0) && !sh_pend_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            skt_pkg::ST_IDLE:
            begin
                if (start)
                    state_next = skt_pkg::ST_SEARCH;
            end
            skt_pkg::ST_SEARCH:
            begin
                state_next = probe_left ? skt_pkg::ST_COMPARE : skt_pkg::ST_DECIDE;
            end
            skt_pkg::ST_COMPARE:
            begin
                state_next = key_eq ? skt_pkg::ST_DECIDE : skt_pkg::ST_SEARCH;
            end
            skt_pkg::ST_DECIDE:
            begin
                state_next = skt_pkg::ST_IDLE;
                if (is_insert && !hit_reg && !is_full) begin
                    state_next = (pos_reg == count_reg) ? skt_pkg::ST_WRITE
                                                        : skt_pkg::ST_SHIFT;
                end else if (is_remove && hit_reg && (pos_reg + CNT_W'(1) < count_reg)) begin
                    state_next = skt_pkg::ST_SHIFT;
                end
            end
            skt_pkg::ST_SHIFT:
            begin
                if (shift_done)
                    state_next = is_insert ? skt_pkg::ST_WRITE : skt_pkg::ST_IDLE;
            end
            skt_pkg::ST_WRITE:
            begin
                state_next = skt_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = skt_pkg::ST_IDLE;
            end
        endcase
    end

    // datapath, memory port and results
    always_comb
    begin
        cmd_next     = cmd_reg;
        key_next     = key_reg;
        pay_next     = pay_reg;
        hit_pay_next = hit_pay_reg;
        lo_next      = lo_reg;
        hi_next      = hi_reg;
        mid_next     = mid_reg;
        pos_next     = pos_reg;
        hit_next     = hit_reg;
        count_next   = count_reg;
        sh_idx_next  = sh_idx_reg;
        sh_cnt_next  = sh_cnt_reg;
        sh_pend_next = sh_pend_reg;
        sh_src_next  = sh_src_reg;
        done_next    = 1'b0;
        status_next  = status_reg;
        found_next   = found_reg;
        index_next   = index_reg;
        out_pay_next = out_pay_reg;
        mem_we       = 1'b0;
        mem_re       = 1'b0;
        mem_waddr    = pos_reg[IDX_W-1:0];
        mem_raddr    = mid_c;
        mem_wdata    = {key_reg, pay_reg};

        unique case (state_reg)
            skt_pkg::ST_IDLE:
            begin
                if (start) begin
                    cmd_next = cmd;
                    key_next = key_in;
                    pay_next = '{data: data_ref, xfm: transform_ref, scale: scale_bits};
                    lo_next  = '0;
                    hi_next  = count_reg;
                end
            end
            skt_pkg::ST_SEARCH:
            begin
                if (probe_left) begin
                    mem_re   = 1'b1;
                    mem_raddr = mid_c;
                    mid_next = mid_c;
                end else begin
                    pos_next = lo_reg;
                    hit_next = 1'b0;
                end
            end
            skt_pkg::ST_COMPARE:
            begin
                if (key_eq) begin
                    hit_next     = 1'b1;
                    pos_next     = CNT_W'(mid_reg);
                    hit_pay_next = skt_pkg::payload_t'(rd_data_reg[skt_pkg::PAY_W-1:0]);
                end else if (key_lt) begin
                    hi_next = CNT_W'(mid_reg);
                end else begin
                    lo_next = CNT_W'(mid_reg) + CNT_W'(1);
                end
            end
            skt_pkg::ST_DECIDE:
            begin
                found_next   = hit_reg;
                index_next   = pos_reg;
                out_pay_next = '0;
                sh_pend_next = 1'b0;
                if (is_insert) begin
                    if (hit_reg) begin
                        // update in place, key unchanged
                        mem_we      = 1'b1;
                        done_next   = 1'b1;
                        status_next = skt_pkg::STAT_UPDATED;
                    end else if (is_full) begin
                        done_next   = 1'b1;
                        status_next = skt_pkg::STAT_FULL;
                    end else begin
                        sh_idx_next = IDX_W'(count_reg - CNT_W'(1));
                        sh_cnt_next = count_reg - pos_reg;
                    end
                end else if (is_remove) begin
                    if (hit_reg) begin
                        status_next = skt_pkg::STAT_REMOVED;
                        sh_idx_next = pos_reg[IDX_W-1:0] + IDX_W'(1);
                        sh_cnt_next = count_reg - pos_reg - CNT_W'(1);
                        if (!(pos_reg + CNT_W'(1) < count_reg)) begin
                            done_next  = 1'b1;
                            count_next = count_reg - CNT_W'(1);
                        end
                    end else begin
                        done_next   = 1'b1;
                        status_next = skt_pkg::STAT_NOT_FOUND;
                    end
                end else begin
                    done_next = 1'b1;
                    if (hit_reg) begin
                        status_next  = skt_pkg::STAT_UPDATED;
                        out_pay_next = hit_pay_reg;
                    end else begin
                        status_next = skt_pkg::STAT_NOT_FOUND;
                    end
                end
            end
            skt_pkg::ST_SHIFT:
            begin
                // read one entry while the previous one is written to its new slot
                if (sh_cnt_reg != '0) begin
                    mem_re       = 1'b1;
                    mem_raddr    = sh_idx_reg;
                    sh_src_next  = sh_idx_reg;
                    sh_pend_next = 1'b1;
                    sh_cnt_next  = sh_cnt_reg - CNT_W'(1);
                    sh_idx_next  = is_insert ? sh_idx_reg - IDX_W'(1)
                                             : sh_idx_reg + IDX_W'(1);
                end else begin
                    sh_pend_next = 1'b0;
                end
                if (sh_pend_reg) begin
                    mem_we    = 1'b1;
                    mem_waddr = is_insert ? sh_src_reg + IDX_W'(1)
                                          : sh_src_reg - IDX_W'(1);
                    mem_wdata = rd_data_reg;
                end
                if (shift_done && !is_insert) begin
                    done_next  = 1'b1;
                    count_next = count_reg - CNT_W'(1);
                end
            end
            skt_pkg::ST_WRITE:
            begin
                mem_we      = 1'b1;
                done_next   = 1'b1;
                status_next = skt_pkg::STAT_INSERTED;
                count_next  = count_reg + CNT_W'(1);
            end
            default:
            begin
                done_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        if (mem_re)
            rd_data_reg <= mem[mem_raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg   <= skt_pkg::ST_IDLE;
            count_reg   <= '0;
            done_reg    <= 1'b0;
            sh_pend_reg <= 1'b0;
            sh_cnt_reg  <= '0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            done_reg    <= done_next;
            sh_pend_reg <= sh_pend_next;
            sh_cnt_reg  <= sh_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg     <= cmd_next;
        key_reg     <= key_next;
        pay_reg     <= pay_next;
        hit_pay_reg <= hit_pay_next;
        lo_reg      <= lo_next;
        hi_reg      <= hi_next;
        mid_reg     <= mid_next;
        pos_reg     <= pos_next;
        hit_reg     <= hit_next;
        sh_idx_reg  <= sh_idx_next;
        sh_src_reg  <= sh_src_next;
        status_reg  <= status_next;
        found_reg   <= found_next;
        index_reg   <= index_next;
        out_pay_reg <= out_pay_next;
    end

    assign busy          = state_reg != skt_pkg::ST_IDLE;
    assign done          = done_reg;
    assign status        = status_reg;
    assign found         = found_reg;
    assign item_index    = index_reg;
    assign entry_count   = count_reg;
    assign data_out      = out_pay_reg.data;
    assign transform_out = out_pay_reg.xfm;
    assign scale_out     = out_pay_reg.scale;

    `SKT_ASSERT_SAME(a_count_bound, clk, rst_n, 1'b1, count_reg <= CAP_C)
    `SKT_ASSERT_NEXT(a_start_busy, clk, rst_n, start && !busy, busy)
    `SKT_ASSERT_SAME(a_port_overlap, clk, rst_n, mem_we && mem_re, mem_waddr != mem_raddr)
    `SKT_ASSERT_SAME(a_full_result, clk, rst_n, done && (status == skt_pkg::STAT_FULL),
        !found && (entry_count == CAP_C))
    `SKT_ASSERT_SAME(a_done_idle, clk, rst_n, done, !busy)

endmodule

[tb/sorted_key_table_top_test.sv]
// ----------------------------------------------------------------------------
// sorted_key_table_top_test
// self-checking bench for the sorted key table: a directed opening covers the
// empty table, key zero, the largest key, updates, misses and command three,
// then grow and shrink phases over a key pool drive the table from empty to
// full and back while a local table model predicts every response
// ----------------------------------------------------------------------------
module sorted_key_table_top_test;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CAPACITY   = skt_pkg::DEF_CAPACITY;
    localparam int CNT_W      = $clog2(skt_pkg::DEF_CAPACITY + 1);
    localparam int WORD_W     = skt_pkg::WORD_W;
    localparam int POOL_N     = 80;
    localparam int RAND_ITEMS = 1880;
    localparam int STALL_MAX  = 2000;
    localparam int DRAIN_CYC  = 100;

    localparam logic [1:0] CMD_LOOKUP     = 2'd2;
    localparam logic [1:0] CMD_LOOKUP_ALT = 2'd3;

    typedef struct {
        logic [1:0]        cmd;
        logic [WORD_W-1:0] key;
        logic [WORD_W-1:0] data;
        logic [WORD_W-1:0] xfm;
        logic [WORD_W-1:0] scale;
        bit                drain;
    } table_op_t;

    typedef struct {
        skt_pkg::status_t  status;
        logic              found;
        logic [CNT_W-1:0]  pos;
        logic [CNT_W-1:0]  cnt;
        logic [WORD_W-1:0] data;
        logic [WORD_W-1:0] xfm;
        logic [WORD_W-1:0] scale;
    } table_result_t;

    logic                clk;
    logic                rst_n = 1'b0;
    logic                start = 1'b0;
    logic [1:0]          cmd = '0;
    logic [WORD_W-1:0]   key = '0;
    logic [WORD_W-1:0]   data_ref = '0;
    logic [WORD_W-1:0]   transform_ref = '0;
    logic [WORD_W-1:0]   scale_bits = '0;
    logic                busy;
    logic                done;
    logic [2:0]          status;
    logic                found;
    logic [CNT_W-1:0]    item_index;
    logic [CNT_W-1:0]    entry_count;
    logic [WORD_W-1:0]   data_out;
    logic [WORD_W-1:0]   transform_out;
    logic [WORD_W-1:0]   scale_out;

    sorted_key_table_top i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .cmd           (cmd),
        .key           (key),
        .data_ref      (data_ref),
        .transform_ref (transform_ref),
        .scale_bits    (scale_bits),
        .done          (done),
        .status        (status),
        .found         (found),
        .item_index    (item_index),
        .entry_count   (entry_count),
        .data_out      (data_out),
        .transform_out (transform_out),
        .scale_out     (scale_out)
    );

    // table model
    logic [WORD_W-1:0] tbl_key [CAPACITY];
    skt_pkg::payload_t tbl_pay [CAPACITY];
    int                tbl_count = 0;

    table_op_t     pending_ops[$];
    table_result_t expected_results[$];
    int            n_total = 0;
    int            n_sent = 0;
    int            n_errors = 0;
    int            n_checked = 0;
    int            stat_seen [5] = '{default: 0};
    int            peak_count = 0;
    int            stall_cycles = 0;

    // key pool for the random part, with presence tracked at generation time
    logic [WORD_W-1:0] key_pool [POOL_N];
    bit                pool_in [POOL_N];
    int                pool_cnt = 0;

    function automatic table_result_t apply_table_op(table_op_t op);
        table_result_t res;
        int            pos;
        bit            hit;
        pos = 0;
        while (pos < tbl_count && tbl_key[pos] < op.key)
            pos++;
        hit = (pos < tbl_count) && (tbl_key[pos] == op.key);
        res.found = hit;
        res.pos = CNT_W'(pos);
        res.data = '0;
        res.xfm = '0;
        res.scale = '0;
        case (op.cmd)
            skt_pkg::CMD_INSERT:
            begin
                if (hit)
                begin
                    tbl_pay[pos] = '{op.data, op.xfm, op.scale};
                    res.status = skt_pkg::STAT_UPDATED;
                end
                else if (tbl_count >= CAPACITY)
                    res.status = skt_pkg::STAT_FULL;
                else
                begin
                    for (int i = tbl_count; i > pos; i--)
                    begin
                        tbl_key[i] = tbl_key[i-1];
                        tbl_pay[i] = tbl_pay[i-1];
                    end
                    tbl_key[pos] = op.key;
                    tbl_pay[pos] = '{op.data, op.xfm, op.scale};
                    tbl_count++;
                    res.status = skt_pkg::STAT_INSERTED;
                end
            end
            skt_pkg::CMD_REMOVE:
            begin
                if (hit)
                begin
                    for (int i = pos; i + 1 < tbl_count; i++)
                    begin
                        tbl_key[i] = tbl_key[i+1];
                        tbl_pay[i] = tbl_pay[i+1];
                    end
                    tbl_count--;
                    res.status = skt_pkg::STAT_REMOVED;
                end
                else
                    res.status = skt_pkg::STAT_NOT_FOUND;
            end
            default:
            begin
                // command three behaves as lookup
                if (hit)
                begin
                    res.data = tbl_pay[pos].data;
                    res.xfm = tbl_pay[pos].xfm;
                    res.scale = tbl_pay[pos].scale;
                    res.status = skt_pkg::STAT_UPDATED;
                end
                else
                    res.status = skt_pkg::STAT_NOT_FOUND;
            end
        endcase
        res.cnt = CNT_W'(tbl_count);
        return res;
    endfunction

    function automatic void queue_op(logic [1:0] c, logic [WORD_W-1:0] k,
                                     logic [WORD_W-1:0] d, logic [WORD_W-1:0] x,
                                     logic [WORD_W-1:0] s, bit drain);
        int idx;
        table_op_t op;
        op = '{c, k, d, x, s, drain};
        pending_ops.insert(pending_ops.size(), op);
        idx = -1;
        for (int i = 0; i < POOL_N; i++)
            if (key_pool[i] == k)
                idx = i;
        if (idx >= 0)
        begin
            if (c == skt_pkg::CMD_INSERT && !pool_in[idx] && pool_cnt < CAPACITY)
            begin
                pool_in[idx] = 1'b1;
                pool_cnt++;
            end
            else if (c == skt_pkg::CMD_REMOVE && pool_in[idx])
            begin
                pool_in[idx] = 1'b0;
                pool_cnt--;
            end
        end
    endfunction

    // random pool slot whose presence matches, or any slot if there is none
    function automatic int pick_pool(bit want_in);
        int first;
        int idx;
        first = int'($urandom_range(POOL_N - 1));
        for (int i = 0; i < POOL_N; i++)
        begin
            idx = (first + i) % POOL_N;
            if (pool_in[idx] == want_in)
                return idx;
        end
        return first;
    endfunction

    // mostly present keys, some pool keys, near misses and random misses
    function automatic logic [WORD_W-1:0] probe_key();
        int                r;
        logic [WORD_W-1:0] base;
        r = int'($urandom_range(99));
        if (r < 60)
            return key_pool[pick_pool(1'b1)];
        else if (r < 80)
            return key_pool[$urandom_range(POOL_N - 1)];
        else if (r < 92)
        begin
            base = key_pool[$urandom_range(POOL_N - 1)];
            return ($urandom_range(1) != 0) ? base + 32'd1 : base - 32'd1;
        end
        return $urandom();
    endfunction

    function automatic int sender_idle_pct();
        if (n_sent < n_total / 3)
            return 18;
        else if (n_sent < 2 * n_total / 3)
            return 75;
        return 0;
    endfunction

    task automatic check_word(string what, logic [WORD_W-1:0] exp_v,
                              logic [WORD_W-1:0] act_v);
        if (act_v !== exp_v)
        begin
            $display("%0t: %s mismatch: expected %0h, actual %0h", $time, what, exp_v, act_v);
            n_errors++;
        end
    endtask

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // driver
    always @(posedge clk or negedge rst_n)
    begin : drive_proc
        table_op_t     acc_op;
        table_op_t     next_op;
        if (!rst_n)
        begin
            start <= 1'b0;
            cmd <= '0;
            key <= '0;
            data_ref <= '0;
            transform_ref <= '0;
            scale_bits <= '0;
        end
        else
        begin
            if (start && !busy)
            begin
                acc_op = '{cmd, key, data_ref, transform_ref, scale_bits, 1'b0};
                expected_results.insert(expected_results.size(), apply_table_op(acc_op));
                n_sent++;
            end
            if (!start || !busy)
            begin
                if (pending_ops.size() != 0
                    && !(pending_ops[0].drain && expected_results.size() != 0)
                    && $urandom_range(99) >= sender_idle_pct())
                begin
                    next_op = pending_ops.pop_front();
                    start <= 1'b1;
                    cmd <= next_op.cmd;
                    key <= next_op.key;
                    data_ref <= next_op.data;
                    transform_ref <= next_op.xfm;
                    scale_bits <= next_op.scale;
                end
                else
                    start <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge clk)
    begin : check_proc
        table_result_t exp_res;
        if (rst_n && done)
        begin
            if (expected_results.size() == 0)
            begin
                $display("%0t: response with no item outstanding: status %0d index %0d",
                         $time, status, item_index);
                n_errors++;
            end
            else
            begin
                exp_res = expected_results.pop_front();
                check_word("status", 32'(exp_res.status), 32'(status));
                check_word("found", 32'(exp_res.found), 32'(found));
                check_word("item_index", 32'(exp_res.pos), 32'(item_index));
                check_word("entry_count", 32'(exp_res.cnt), 32'(entry_count));
                check_word("data_out", exp_res.data, data_out);
                check_word("transform_out", exp_res.xfm, transform_out);
                check_word("scale_out", exp_res.scale, scale_out);
                stat_seen[exp_res.status]++;
                if (int'(exp_res.cnt) > peak_count)
                    peak_count = int'(exp_res.cnt);
                n_checked++;
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((start && !busy) || done)
                stall_cycles <= 0;
            else
                stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_MAX)
            begin
                $display("%0t: no progress for %0d cycles", $time, STALL_MAX);
                $display("status: fail");
                $finish;
            end
        end
    end

    initial
    begin : stim_proc
        logic [WORD_W-1:0] cand;
        bit                dup;
        bit                growing;
        bit                drain_next;
        int                phase_left;
        int                r;
        int                idx;

        // distinct pool keys, the extremes among them
        key_pool[0] = '0;
        key_pool[1] = '1;
        for (int i = 2; i < POOL_N; i++)
        begin
            do
            begin
                cand = (i % 3 == 0) ? key_pool[i-1] + $urandom_range(3, 1) : $urandom();
                dup = 1'b0;
                for (int j = 0; j < i; j++)
                    if (key_pool[j] == cand)
                        dup = 1'b1;
            end
            while (dup);
            key_pool[i] = cand;
        end
        foreach (pool_in[i])
            pool_in[i] = 1'b0;

        // directed: empty table, key zero, largest key, unsigned order, misses
        queue_op(CMD_LOOKUP, '0, $urandom(), $urandom(), $urandom(), 1'b0);
        queue_op(skt_pkg::CMD_REMOVE, 32'd5, $urandom(), $urandom(), $urandom(), 1'b0);
        queue_op(skt_pkg::CMD_INSERT, '0, '0, '0, '0, 1'b0);
        queue_op(skt_pkg::CMD_INSERT, '1, '1, '1, '1, 1'b0);
        queue_op(skt_pkg::CMD_INSERT, 32'h8000_0000, $urandom(), $urandom(), $urandom(), 1'b0);
        queue_op(skt_pkg::CMD_INSERT, 32'd1, $urandom(), $urandom(), $urandom(), 1'b0);
        queue_op(skt_pkg::CMD_INSERT, 32'h7fff_ffff, $urandom(), $urandom(), $urandom(), 1'b0);
        queue_op(CMD_LOOKUP, '1, $urandom(), $urandom(), $urandom(), 1'b0);
        queue_op(CMD_LOOKUP, '0, $urandom(), $urandom(), $urandom(), 1'b0);
        queue_op(CMD_LOOKUP, 32'h8000_0001, $urandom(), $urandom(), $urandom(), 1'b0);
        queue_op(skt_pkg::CMD_INSERT, 32'd1, $urandom(), $urandom(), $urandom(), 1'b0);
        queue_op(CMD_LOOKUP_ALT, 32'd1, $urandom(), $urandom(), $urandom(), 1'b0);
        queue_op(skt_pkg::CMD_REMOVE, 32'h8000_0000, $urandom(), $urandom(), $urandom(), 1'b0);
        queue_op(skt_pkg::CMD_REMOVE, 32'h8000_0000, $urandom(), $urandom(), $urandom(), 1'b0);
        queue_op(CMD_LOOKUP, 32'h8000_0000, $urandom(), $urandom(), $urandom(), 1'b0);
        queue_op(skt_pkg::CMD_REMOVE, '1, $urandom(), $urandom(), $urandom(), 1'b0);
        queue_op(skt_pkg::CMD_REMOVE, '0, $urandom(), $urandom(), $urandom(), 1'b0);
        queue_op(skt_pkg::CMD_REMOVE, 32'd1, $urandom(), $urandom(), $urandom(), 1'b0);
        queue_op(skt_pkg::CMD_REMOVE, 32'h7fff_ffff, $urandom(), $urandom(), $urandom(), 1'b0);
        queue_op(CMD_LOOKUP_ALT, '1, $urandom(), $urandom(), $urandom(), 1'b0);

        // random: alternate filling toward full and emptying toward zero
        growing = 1'b1;
        drain_next = 1'b0;
        phase_left = 180;
        for (int n = 0; n < RAND_ITEMS; n++)
        begin
            if (phase_left == 0)
            begin
                growing = !growing;
                phase_left = growing ? 180 : 160;
                drain_next = 1'b1;
            end
            phase_left--;
            r = int'($urandom_range(99));
            if ((growing && r < 65) || (!growing && r >= 65 && r < 75))
            begin
                if ($urandom_range(99) < 80)
                    idx = pick_pool(1'b0);
                else
                    idx = int'($urandom_range(POOL_N - 1));
                queue_op(skt_pkg::CMD_INSERT, key_pool[idx], $urandom(), $urandom(),
                         $urandom(), drain_next);
            end
            else if ((growing && r < 75) || (!growing && r < 65))
            begin
                if ($urandom_range(99) < 85)
                    cand = key_pool[pick_pool(1'b1)];
                else
                    cand = probe_key();
                queue_op(skt_pkg::CMD_REMOVE, cand, $urandom(), $urandom(), $urandom(),
                         drain_next);
            end
            else
                queue_op($urandom_range(3) == 0 ? CMD_LOOKUP_ALT : CMD_LOOKUP, probe_key(),
                         $urandom(), $urandom(), $urandom(), drain_next);
            drain_next = 1'b0;
        end
        n_total = pending_ops.size();

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        while (n_sent != n_total || expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYC) @(posedge clk);

        $display("covered %0d items: %0d inserted, %0d updated or hit, %0d removed",
                 n_checked, stat_seen[skt_pkg::STAT_INSERTED],
                 stat_seen[skt_pkg::STAT_UPDATED], stat_seen[skt_pkg::STAT_REMOVED]);
        $display("%0d missed, %0d refused as full, peak occupancy %0d of %0d, %0d mismatches",
                 stat_seen[skt_pkg::STAT_NOT_FOUND], stat_seen[skt_pkg::STAT_FULL],
                 peak_count, CAPACITY, n_errors);
        if (n_errors == 0 && expected_results.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
